FILE: rtl/core/tdocc_pkg.sv
package tdocc_pkg;

  typedef enum logic [1:0] {
    MODE_BINARY = 2'd0,
    MODE_OCTAL  = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_HEX_ALT = 2'd3
  } digit_mode_t;

  localparam int unsigned WordWidth = 16;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned PosWidth  = 4;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;
  localparam logic [CharWidth-1:0] CharOne   = 8'h31;
  localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
  localparam logic [CharWidth-1:0] CharUpF   = 8'h46;
  localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
  localparam logic [CharWidth-1:0] CharLowF  = 8'h66;

  localparam logic [PosWidth-1:0] BinaryLastPos = 4'd15;
  localparam logic [PosWidth-1:0] OctalLastPos  = 4'd1;
  localparam logic [PosWidth-1:0] HexLastPos    = 4'd3;

  localparam logic [0:0] RegDigitMode = 1'b0;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [CharWidth-1:0] char_t;
  typedef logic [PosWidth-1:0]  pos_t;

  function automatic logic [3:0] hex_value(input char_t c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CharZero && c <= CharNine) begin
      v = c[3:0];
    end else if ((c >= CharUpA && c <= CharUpF) || (c >= CharLowA && c <= CharLowF)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/tdocc_char_if.sv
interface tdocc_char_if;
  logic                      valid;
  logic                      ready;
  logic [tdocc_pkg::CharWidth-1:0] char_code;
  logic                      last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/core/tdocc_sum_if.sv
interface tdocc_sum_if;
  logic                      valid;
  logic                      ready;
  logic [tdocc_pkg::WordWidth-1:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink (input valid, input checksum, output ready);
endinterface

FILE: rtl/core/text_digit_ones_complement_checksum.sv
// The checksum is registered and presented in the cycle after the transfer of the last character.
// Throughput: one character per cycle; the sum and word packing update in a single pass.
// A result waiting at the output holds off new characters until it is taken.
// Reset (rst, synchronous, active high) selects binary mode and clears the running sum,
// the partial word, the character position and the output valid flag.
module text_digit_ones_complement_checksum (
  input  logic              clk,
  input  logic              rst,
  tdocc_char_if.sink        chars,
  tdocc_sum_if.source       result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tdocc_pkg::*;

  digit_mode_t digit_mode;
  word_t       running_sum;
  word_t       running_sum_next;
  word_t       partial_word;
  word_t       partial_word_next;
  pos_t        char_position;
  pos_t        char_position_next;
  word_t       checksum;
  logic        result_valid;

  word_t       packed_word;
  logic        word_done;
  logic [WordWidth:0] raw_sum;
  word_t       folded_sum;
  logic        in_xfer;
  logic        cfg_write;
  word_t       char_offset;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegDigitMode);
  assign prdata    = (paddr[2] == RegDigitMode) ? {30'd0, digit_mode} : 32'd0;

  assign chars.ready     = !result_valid || result.ready;
  assign in_xfer         = chars.valid && chars.ready;
  assign result.valid    = result_valid;
  assign result.checksum = checksum;

  assign char_offset = {{(WordWidth-CharWidth){1'b0}}, chars.char_code} - word_t'(CharZero);

  always_comb begin
    packed_word = partial_word;
    word_done   = 1'b0;
    case (digit_mode)
      MODE_BINARY: begin
        if (chars.char_code == CharOne) begin
          packed_word[BinaryLastPos - char_position] = 1'b1;
        end
        word_done = (char_position == BinaryLastPos);
      end
      MODE_OCTAL: begin
        if (char_position == '0) begin
          packed_word = {char_offset[WordWidth-4:0], 3'b000};
        end else begin
          packed_word = partial_word + char_offset;
        end
        word_done = (char_position >= OctalLastPos);
      end
      default: begin
        packed_word = {partial_word[WordWidth-5:0], hex_value(chars.char_code)};
        word_done   = (char_position >= HexLastPos);
      end
    endcase
    word_done = word_done || chars.last_char;
  end

  assign raw_sum    = {1'b0, running_sum} + {1'b0, packed_word};
  assign folded_sum = raw_sum[WordWidth-1:0] + word_t'(raw_sum[WordWidth]);

  always_comb begin
    running_sum_next   = running_sum;
    partial_word_next  = partial_word;
    char_position_next = char_position;
    if (cfg_write) begin
      running_sum_next   = '0;
      partial_word_next  = '0;
      char_position_next = '0;
    end else if (in_xfer) begin
      if (chars.last_char) begin
        running_sum_next   = '0;
        partial_word_next  = '0;
        char_position_next = '0;
      end else if (word_done) begin
        running_sum_next   = folded_sum;
        partial_word_next  = '0;
        char_position_next = '0;
      end else begin
        partial_word_next  = packed_word;
        char_position_next = char_position + pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_mode    <= MODE_BINARY;
      running_sum   <= '0;
      partial_word  <= '0;
      char_position <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        digit_mode <= digit_mode_t'(pwdata[1:0]);
      end
      running_sum   <= running_sum_next;
      partial_word  <= partial_word_next;
      char_position <= char_position_next;
      if (in_xfer && chars.last_char) begin
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && chars.last_char) begin
      checksum <= ~folded_sum;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && chars.last_char) |=> (result_valid && running_sum == '0 && char_position == '0))
    else $error("last character did not produce a result and clear the message state");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ready) |-> !chars.ready)
    else $error("character accepted while a result is stalled");

  assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (running_sum == '0 && partial_word == '0 && char_position == '0))
    else $error("mode write did not start a new message");

endmodule

FILE: tb/sv/text_digit_ones_complement_checksum_test.sv
module text_digit_ones_complement_checksum_test;
  import tdocc_pkg::*;

  typedef struct {
    char_t       code;
    logic        last;
    int unsigned gap;
  } char_item_t;

  localparam logic [2:0] DigitModeAddr = {RegDigitMode, 2'b00};
  localparam int unsigned PhaseChars = 160;
  localparam int unsigned RandomPhases = 12;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tdocc_char_if char_bus ();
  tdocc_sum_if  sum_bus ();

  text_digit_ones_complement_checksum uut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_bus.sink),
    .result  (sum_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  digit_mode_t model_mode;
  word_t       model_sum;
  word_t       model_word;
  pos_t        model_pos;

  char_item_t  char_backlog[$];
  word_t       expected_sums[$];
  char_item_t  staged_char;

  int unsigned queued_chars;
  int unsigned accepted_chars;
  int unsigned checked_sums;
  int unsigned error_count;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned quiet_left;

  function automatic void clear_message();
    model_sum  = '0;
    model_word = '0;
    model_pos  = '0;
  endfunction

  function automatic void fold_char(char_t c, logic last);
    int unsigned next_pos;
    int unsigned word_len;
    word_t       digit;
    logic [16:0] wide;
    next_pos = model_pos + 1;
    case (model_mode)
      MODE_BINARY: begin
        word_len = 16;
        if (c == CharOne) begin
          model_word[15 - model_pos] = 1'b1;
        end
      end
      MODE_OCTAL: begin
        word_len = 2;
        digit = word_t'(c) - word_t'(CharZero);
        model_word = (model_pos == 0) ? word_t'(digit << 3) : word_t'(model_word + digit);
      end
      default: begin
        word_len = 4;
        if (c >= CharZero && c <= CharNine) begin
          digit = word_t'(c - CharZero);
        end else if (c >= CharUpA && c <= CharUpF) begin
          digit = word_t'(c - CharUpA) + 16'd10;
        end else if (c >= CharLowA && c <= CharLowF) begin
          digit = word_t'(c - CharLowA) + 16'd10;
        end else begin
          digit = '0;
        end
        model_word = {model_word[11:0], digit[3:0]};
      end
    endcase
    if (next_pos >= word_len || last) begin
      wide = {1'b0, model_sum} + {1'b0, model_word};
      model_sum = wide[15:0] + word_t'(wide[16]);
      model_word = '0;
      next_pos = 0;
    end
    model_pos = pos_t'(next_pos);
    if (last) begin
      expected_sums.push_back(~model_sum);
      clear_message();
    end
  endfunction

  function automatic void queue_char(char_t c, logic last, int unsigned gap);
    char_item_t item;
    item.code = c;
    item.last = last;
    item.gap  = gap;
    char_backlog.push_back(item);
    queued_chars++;
  endfunction

  function automatic char_t random_digit(digit_mode_t m);
    int unsigned v;
    if ($urandom_range(0, 9) == 0) begin
      return char_t'($urandom_range(0, 255));
    end
    case (m)
      MODE_BINARY: return $urandom_range(0, 1) ? CharOne : CharZero;
      MODE_OCTAL:  return char_t'(CharZero + $urandom_range(0, 7));
      default: begin
        v = $urandom_range(0, 21);
        if (v < 10) begin
          return char_t'(CharZero + v);
        end else if (v < 16) begin
          return char_t'(CharUpA + v - 10);
        end
        return char_t'(CharLowA + v - 16);
      end
    endcase
  endfunction

  task automatic queue_message(digit_mode_t m, int unsigned len, bit ends);
    bit quiet;
    quiet = ($urandom_range(0, 4) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      queue_char(random_digit(m), ends && (i == len - 1), quiet ? 0 : $urandom_range(0, 8));
    end
  endtask

  task automatic drain();
    while (accepted_chars != queued_chars || expected_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_digit_mode(digit_mode_t m);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DigitModeAddr;
    pwdata  <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_mode = m;
    clear_message();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(m)) begin
      $display("%0t: digit_mode readback expected %h actual %h", $time, 32'(m), prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        fold_char(char_bus.char_code, char_bus.last_char);
        accepted_chars++;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          char_bus.valid <= 1'b0;
        end else if (char_backlog.size() != 0) begin
          staged_char = char_backlog.pop_front();
          char_bus.valid     <= 1'b1;
          char_bus.char_code <= staged_char.code;
          char_bus.last_char <= staged_char.last;
          gap_left <= staged_char.gap;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sum_bus.ready <= 1'b0;
      hold_left = 0;
      quiet_left = 0;
    end else begin
      if (sum_bus.valid && sum_bus.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: checksum expected none actual %h", $time, sum_bus.checksum);
          error_count++;
        end else begin
          if (sum_bus.checksum !== expected_sums[0]) begin
            $display("%0t: checksum expected %h actual %h", $time, expected_sums[0],
                     sum_bus.checksum);
            error_count++;
          end
          void'(expected_sums.pop_front());
          checked_sums++;
        end
        if (quiet_left != 0) begin
          quiet_left--;
          hold_left = 0;
        end else begin
          hold_left = $urandom_range(0, 8);
          if ($urandom_range(0, 19) == 0) begin
            quiet_left = $urandom_range(5, 30);
          end
        end
      end else if (sum_bus.valid && hold_left != 0) begin
        hold_left--;
      end
      sum_bus.ready <= (hold_left == 0);
    end
  end

  initial begin
    int unsigned phase_chars;
    int unsigned len;
    digit_mode_t m;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    char_bus.valid = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    sum_bus.ready = 1'b0;
    queued_chars = 0;
    accepted_chars = 0;
    checked_sums = 0;
    error_count = 0;
    model_mode = MODE_BINARY;
    clear_message();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Binary after reset: a short final word is left-aligned.
    queue_char(CharOne, 1'b0, 0);
    queue_char(8'hFF, 1'b0, 2);
    queue_char(CharOne, 1'b0, 0);
    queue_char(8'h00, 1'b0, 1);
    queue_char(CharOne, 1'b1, 0);
    drain();

    // Octal pairs, including bytes below the digit range and a lone final character.
    set_digit_mode(MODE_OCTAL);
    queue_char(char_t'(CharZero + 7), 1'b0, 0);
    queue_char(char_t'(CharZero + 7), 1'b0, 0);
    queue_char(8'h00, 1'b0, 3);
    queue_char(8'hFF, 1'b0, 0);
    queue_char(8'h20, 1'b1, 0);
    queue_char(char_t'(CharZero + 5), 1'b0, 0);
    drain();

    // The mode write drops the unfinished octal message above.
    set_digit_mode(MODE_HEX);
    queue_char(CharUpF, 1'b0, 0);
    queue_char(CharLowF, 1'b0, 1);
    queue_char(CharUpA, 1'b0, 0);
    queue_char(CharLowA, 1'b0, 0);
    queue_char(CharNine, 1'b0, 0);
    queue_char(8'h67, 1'b0, 0);
    queue_char(CharZero, 1'b1, 0);
    drain();

    set_digit_mode(MODE_HEX_ALT);
    queue_char(char_t'(CharUpA + 1), 1'b0, 0);
    queue_char(char_t'(CharLowA + 2), 1'b1, 0);
    drain();

    for (int unsigned p = 0; p < RandomPhases; p++) begin
      m = digit_mode_t'((p + 1) % 4);
      set_digit_mode(m);
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 20);
        queue_message(m, len, 1'b1);
        phase_chars += len;
      end
      if (p % 3 == 1) begin
        queue_message(m, $urandom_range(1, 5), 1'b0);
      end
      drain();
    end

    $display("Sent %0d characters and compared %0d checksums in every digit mode,",
             accepted_chars, checked_sums);
    $display("with mode changes between messages and in the middle of one.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tdocc_pkg.sv
rtl/core/tdocc_char_if.sv
rtl/core/tdocc_sum_if.sv
rtl/core/text_digit_ones_complement_checksum.sv
tb/sv/text_digit_ones_complement_checksum_test.sv
